@@ rtl/core/frhc_pkg.sv @@
// ----------------------------------------------------------------------------
// frhc_pkg
// Shared types and constants for the fan rate hold controller.
// ----------------------------------------------------------------------------
`default_nettype none

package frhc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RET_TARGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd5;

    localparam logic [15:0] TARGET_RST     = 16'd32768;
    localparam logic [15:0] RET_TARGET_RST = 16'd31196;
    localparam logic [23:0] HOLD_TICKS_RST = 24'd1000;
    localparam logic [15:0] GAIN_RST       = 16'd1280;
    localparam logic [11:0] OFFSET_RST     = 12'd2099;
    localparam logic [15:0] THRESHOLD_RST  = 16'd655;

    localparam logic [1:0] PHASE_SEEK   = 2'd0;
    localparam logic [1:0] PHASE_HOLD   = 2'd1;
    localparam logic [1:0] PHASE_RETURN = 2'd2;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    // Thrust limits in Q8.8: full scale is 10.0, the deadband edge is 8.0.
    localparam logic [16:0] THRUST_MAX_Q = 17'd2560;
    localparam logic [16:0] THRUST_MIN_Q = 17'd2048;

    // Division by 5 as multiplication by ceil(2^22 / 5), exact below 2^22.
    localparam int          RCP_W     = 20;
    localparam int          RCP_SHIFT = 22;
    localparam logic [19:0] RCP_FIVE  = 20'd838861;

    localparam int DRIVE_W = 12;

    typedef struct packed {
        logic [15:0] target_code;
        logic [15:0] return_target_code;
        logic [23:0] hold_ticks;
        logic [15:0] gain;
        logic [11:0] offset_thrust;
        logic [15:0] settle_threshold;
    } cfg_t;

    typedef struct packed {
        logic [15:0] gain_term;
        logic        neg;
        logic        zero_thrust;
        logic        done;
        logic [1:0]  phase;
    } trk_t;

endpackage

`default_nettype wire

@@ rtl/core/frhc_track.sv @@
// ----------------------------------------------------------------------------
// frhc_track
// Phase tracking, error against the active target and the gain product.
// ----------------------------------------------------------------------------
`default_nettype none

module frhc_track
    import frhc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        sample_valid,
    input  wire logic [15:0] sample,
    output logic             sample_free,
    output logic             trk_valid,
    output trk_t             trk,
    input  wire logic        trk_free
);

    logic [23:0] hold_count_reg, hold_count_next;
    logic        hold_started_reg, hold_started_next;
    logic        returning_reg, returning_next;
    logic        finished_reg, finished_next;
    logic        valid_reg;
    trk_t        trk_reg, trk_next;
    logic        load;
    logic [15:0] code;
    logic [15:0] tgt;
    logic        neg;
    logic [15:0] mag;
    logic        in_band;
    logic [31:0] product;

    assign sample_free = !valid_reg || trk_free;
    assign load        = sample_valid && sample_free;
    assign trk_valid   = valid_reg;
    assign trk         = trk_reg;

    always_comb
    begin
        returning_next    = returning_reg
                            || (hold_started_reg && (hold_count_reg > cfg.hold_ticks));
        hold_count_next   = hold_count_reg;
        hold_started_next = hold_started_reg;
        finished_next     = finished_reg;
        if (hold_started_reg && (hold_count_reg != '1))
        begin
            hold_count_next = hold_count_reg + 24'd1;
        end

        code    = sample ^ 16'h8000;
        tgt     = returning_next ? cfg.return_target_code : cfg.target_code;
        neg     = code < tgt;
        mag     = neg ? (tgt - code) : (code - tgt);
        in_band = mag < cfg.settle_threshold;
        product = 32'(mag) * 32'(cfg.gain);

        if (in_band && !hold_started_reg)
        begin
            hold_started_next = 1'b1;
            hold_count_next   = '0;
        end
        if (returning_next && in_band)
        begin
            finished_next = 1'b1;
        end

        trk_next.gain_term   = product[31:16];
        trk_next.neg         = neg;
        trk_next.zero_thrust = returning_next || (mag == 16'd0);
        trk_next.done        = finished_next;
        if (finished_next)
        begin
            trk_next.phase = PHASE_DONE;
        end
        else if (returning_next)
        begin
            trk_next.phase = PHASE_RETURN;
        end
        else if (hold_started_next)
        begin
            trk_next.phase = PHASE_HOLD;
        end
        else
        begin
            trk_next.phase = PHASE_SEEK;
        end

        // Once done, the state freezes and every result reads as done.
        if (finished_reg)
        begin
            returning_next    = returning_reg;
            hold_count_next   = hold_count_reg;
            hold_started_next = hold_started_reg;
            trk_next.done     = 1'b1;
            trk_next.phase    = PHASE_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            hold_count_reg   <= '0;
            hold_started_reg <= 1'b0;
            returning_reg    <= 1'b0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            if (sample_free)
            begin
                valid_reg <= sample_valid;
            end
            if (load)
            begin
                hold_count_reg   <= hold_count_next;
                hold_started_reg <= hold_started_next;
                returning_reg    <= returning_next;
                finished_reg     <= finished_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            trk_reg <= trk_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/frhc_drive.sv @@
// ----------------------------------------------------------------------------
// frhc_drive
// Thrust saturation and deadband, DAC scaling and fan routing.
// ----------------------------------------------------------------------------
`default_nettype none

module frhc_drive
    import frhc_pkg::*;
#(
    parameter int DAC_BITS = 12
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               trk_valid,
    input  wire trk_t               trk,
    output logic                    trk_free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DRIVE_W-1:0]      pos_drive,
    output logic [DRIVE_W-1:0]      neg_drive,
    output logic                    drive_valid,
    output logic [1:0]              phase
);

    localparam int SCL_W = 12 + DAC_BITS;
    localparam int DIV_W = SCL_W - 9;
    localparam int PRD_W = (DIV_W + RCP_W > RCP_SHIFT + DRIVE_W)
                           ? DIV_W + RCP_W : RCP_SHIFT + DRIVE_W;
    localparam logic [DAC_BITS-1:0] FULL = '1;

    logic               b_valid_reg;
    logic [SCL_W-1:0]   scaled_reg, scaled_next;
    logic               b_neg_reg;
    logic               b_done_reg;
    logic [1:0]         b_phase_reg;
    logic               out_valid_reg;
    logic [DRIVE_W-1:0] pos_reg, pos_next;
    logic [DRIVE_W-1:0] neg_reg, neg_next;
    logic               dvalid_reg;
    logic [1:0]         phase_reg;
    logic               out_free;
    logic               b_free;
    logic [16:0]        thrust_sum;
    logic [11:0]        thrust;
    logic [DIV_W-1:0]   div_in;
    logic [PRD_W-1:0]   div_prod;
    logic [DRIVE_W-1:0] code;

    assign out_free  = !out_valid_reg || !out_stall;
    assign b_free    = !b_valid_reg || out_free;
    assign trk_free  = b_free;
    assign out_valid = out_valid_reg;
    assign pos_drive = pos_reg;
    assign neg_drive = neg_reg;
    assign drive_valid = dvalid_reg;
    assign phase     = phase_reg;

    always_comb
    begin
        thrust_sum = 17'(trk.gain_term) + 17'(cfg.offset_thrust);
        if (trk.zero_thrust || trk.done || (thrust_sum < THRUST_MIN_Q))
        begin
            thrust = '0;
        end
        else if (thrust_sum > THRUST_MAX_Q)
        begin
            thrust = THRUST_MAX_Q[11:0];
        end
        else
        begin
            thrust = thrust_sum[11:0];
        end
        scaled_next = SCL_W'(thrust) * SCL_W'(FULL);
    end

    // Division by 2560 is a shift by nine and a division by five.
    always_comb
    begin
        div_in   = scaled_reg[SCL_W-1:9];
        div_prod = PRD_W'(div_in) * PRD_W'(RCP_FIVE);
        code     = div_prod[RCP_SHIFT +: DRIVE_W];
        if (b_done_reg)
        begin
            pos_next = '0;
            neg_next = '0;
        end
        else if (b_neg_reg)
        begin
            pos_next = '0;
            neg_next = code;
        end
        else
        begin
            pos_next = code;
            neg_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= trk_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (trk_valid && b_free)
        begin
            scaled_reg  <= scaled_next;
            b_neg_reg   <= trk.neg;
            b_done_reg  <= trk.done;
            b_phase_reg <= trk.phase;
        end
        if (b_valid_reg && out_free)
        begin
            pos_reg    <= pos_next;
            neg_reg    <= neg_next;
            dvalid_reg <= !b_done_reg;
            phase_reg  <= b_phase_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fan_rate_hold_controller.sv @@
// Throughput: one sample per cycle while out_stall is low; each sample passes
// through the stages in order: an input register, the tracking stage with
// the gain multiplier, the thrust and scaling stage, and the output register.
// Stalls back up stage by stage, filling any bubbles.
// Reset clears the pipeline, the hold state and all settings to defaults.
// ----------------------------------------------------------------------------
// fan_rate_hold_controller
// Proportional fan rate controller with bang offset, deadband and hold phases.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_rate_hold_controller
    import frhc_pkg::*;
#(
    parameter int DAC_BITS = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [15:0]   gyro_sample,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DRIVE_W-1:0]        pos_drive,
    output logic [DRIVE_W-1:0]        neg_drive,
    output logic                      drive_valid,
    output logic [1:0]                phase,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]          cfg_data
);

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic [15:0] sample_reg;
    logic        s1_free;
    logic        a_free;
    logic        trk_valid;
    trk_t        trk;
    logic        trk_free;

    assign cfg_ready = 1'b1;
    assign s1_free   = !s1_valid_reg || a_free;
    assign in_stall  = !s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_code        <= TARGET_RST;
            cfg_reg.return_target_code <= RET_TARGET_RST;
            cfg_reg.hold_ticks         <= HOLD_TICKS_RST;
            cfg_reg.gain               <= GAIN_RST;
            cfg_reg.offset_thrust      <= OFFSET_RST;
            cfg_reg.settle_threshold   <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET:     cfg_reg.target_code        <= cfg_data[15:0];
                REG_RET_TARGET: cfg_reg.return_target_code <= cfg_data[15:0];
                REG_HOLD_TICKS: cfg_reg.hold_ticks         <= cfg_data;
                REG_GAIN:       cfg_reg.gain               <= cfg_data[15:0];
                REG_OFFSET:     cfg_reg.offset_thrust      <= cfg_data[11:0];
                REG_THRESHOLD:  cfg_reg.settle_threshold   <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            sample_reg <= gyro_sample;
        end
    end

    frhc_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (s1_valid_reg),
        .sample       (sample_reg),
        .sample_free  (a_free),
        .trk_valid    (trk_valid),
        .trk          (trk),
        .trk_free     (trk_free)
    );

    frhc_drive #(
        .DAC_BITS (DAC_BITS)
    ) u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .trk_valid   (trk_valid),
        .trk         (trk),
        .trk_free    (trk_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pos_drive   (pos_drive),
        .neg_drive   (neg_drive),
        .drive_valid (drive_valid),
        .phase       (phase)
    );

endmodule

`default_nettype wire
